// File: hdl/vchf_pkg.sv
// Shared sizes, op codes and controller/datapath interface types for the veto hit filter.
package vchf_pkg;

  // Buffer depths
  localparam int MAX_HITS   = 32;
  localparam int MAX_VETOES = 32;

  // Derived widths: counters hold the depth itself, addresses index the store
  localparam int HIT_AW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int HIT_CW  = $clog2(MAX_HITS + 1);
  localparam int VETO_AW = (MAX_VETOES > 1) ? $clog2(MAX_VETOES) : 1;
  localparam int VETO_CW = $clog2(MAX_VETOES + 1);

  // Field and register widths
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int DIFF_W  = TIME_W + 2;
  localparam int CFG_IW  = 2;

  // Register reset values
  localparam logic [WIN_W-1:0] DPW_RESET = 16'd2048;
  localparam logic [WIN_W-1:0] VWA_RESET = 16'd12288;
  localparam logic [WIN_W-1:0] VWB_RESET = 16'd12288;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_DPW = 2'd0;
  localparam logic [CFG_IW-1:0] REG_VWA = 2'd1;
  localparam logic [CFG_IW-1:0] REG_VWB = 2'd2;

  // Op codes
  localparam logic [1:0] OP_DET  = 2'd0;
  localparam logic [1:0] OP_VETO = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ld;         // store the accepted load item
    logic i_clr;
    logic i_inc;
    logic j_set;      // j = i + 1
    logic j_inc;
    logic v_clr;
    logic v_inc;
    logic rd_i;       // read hit store at i
    logic rd_j;       // read hit store at j
    logic rd_v;       // read veto store at v
    logic ti_ld;      // latch current hit time
    logic mark_j;
    logic mark_i;
    logic pend_ld;    // push read hit into the output lookahead
    logic emit_final;
    logic clr_event;
  } vchf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic i_end;
    logic i_rm;
    logic j_end;
    logic j_rm;
    logic v_end;
    logic below_low;
    logic below_high;
  } vchf_stat_t;

endpackage

// File: hdl/vchf_ctrl.sv
// Controller state machine that sequences loading, filtering and emitting of one event.
module vchf_ctrl
  import vchf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] op_i,
  input  vchf_stat_t stat_i,
  output vchf_cmd_t  cmd_o,
  output logic       busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUTER,
    S_OUTER_RD,
    S_INNER,
    S_INNER_RD,
    S_VETO,
    S_VETO_RD,
    S_EMIT,
    S_EMIT_RD,
    S_FINAL
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (op_i == OP_DET || op_i == OP_VETO) begin
            cmd_o.ld = 1'b1;
          end else if (op_i == OP_END) begin
            cmd_o.i_clr = 1'b1;
            state_d     = S_OUTER;
          end
        end
      end
      // Pick the next hit still present
      S_OUTER: begin
        if (stat_i.i_end) begin
          cmd_o.i_clr = 1'b1;
          state_d     = S_EMIT;
        end else if (stat_i.i_rm) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.rd_i = 1'b1;
          state_d    = S_OUTER_RD;
        end
      end
      S_OUTER_RD: begin
        cmd_o.ti_ld = 1'b1;
        cmd_o.j_set = 1'b1;
        state_d     = S_INNER;
      end
      // Double-pulse scan over later hits
      S_INNER: begin
        if (stat_i.j_end) begin
          cmd_o.v_clr = 1'b1;
          state_d     = S_VETO;
        end else if (stat_i.j_rm) begin
          cmd_o.j_inc = 1'b1;
        end else begin
          cmd_o.rd_j = 1'b1;
          state_d    = S_INNER_RD;
        end
      end
      S_INNER_RD: begin
        if (stat_i.below_low) begin
          cmd_o.v_clr = 1'b1;
          state_d     = S_VETO;
        end else begin
          cmd_o.mark_j = stat_i.below_high;
          cmd_o.j_inc  = 1'b1;
          state_d      = S_INNER;
        end
      end
      // Veto scan for the current hit
      S_VETO: begin
        if (stat_i.v_end) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_OUTER;
        end else begin
          cmd_o.rd_v = 1'b1;
          state_d    = S_VETO_RD;
        end
      end
      S_VETO_RD: begin
        if (stat_i.below_low) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_OUTER;
        end else if (stat_i.below_high) begin
          cmd_o.mark_i = 1'b1;
          cmd_o.i_inc  = 1'b1;
          state_d      = S_OUTER;
        end else begin
          cmd_o.v_inc = 1'b1;
          state_d     = S_VETO;
        end
      end
      // Walk survivors with one result of lookahead
      S_EMIT: begin
        if (stat_i.i_end) begin
          state_d = S_FINAL;
        end else if (stat_i.i_rm) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.rd_i = 1'b1;
          state_d    = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd_o.pend_ld = 1'b1;
        cmd_o.i_inc   = 1'b1;
        state_d       = S_EMIT;
      end
      S_FINAL: begin
        cmd_o.emit_final = 1'b1;
        cmd_o.clr_event  = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

// File: hdl/vchf_datapath.sv
// Datapath: window registers, hit and veto stores, removal marks, comparator and result registers.
module vchf_datapath
  import vchf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [WIN_W-1:0]  cfg_wdata_i,
  input  logic [1:0]        op_i,
  input  logic [TIME_W-1:0] hit_time_i,
  input  vchf_cmd_t         cmd_i,
  output vchf_stat_t        stat_o,
  output logic              result_valid_o,
  output logic [TIME_W-1:0] kept_time_o,
  output logic              kept_valid_o,
  output logic              last_o,
  output logic              overflow_o
);

  logic [WIN_W-1:0]  dpw_q, vwa_q, vwb_q;
  logic [TIME_W-1:0] det_mem [MAX_HITS];
  logic [TIME_W-1:0] veto_mem [MAX_VETOES];
  logic [TIME_W-1:0] det_rdata_q, veto_rdata_q;
  logic [HIT_CW-1:0] dcnt_q, i_q, j_q;
  logic [VETO_CW-1:0] vcnt_q, v_q;
  logic [MAX_HITS-1:0] marks_q;
  logic              ovf_q;
  logic              veto_sel_q;
  logic [TIME_W-1:0] ti_q, pend_q;
  logic              have_pend_q;
  logic              res_valid_q, res_kept_q, res_last_q, res_ovf_q;
  logic [TIME_W-1:0] res_time_q;

  logic [HIT_AW-1:0]  det_addr;
  logic               det_we, veto_we;
  logic [TIME_W-1:0]  cmp_b;
  logic [WIN_W-1:0]   win_lo, win_hi;
  logic signed [DIFF_W-1:0] diff, lo_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpw_q <= DPW_RESET;
      vwa_q <= VWA_RESET;
      vwb_q <= VWB_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DPW: dpw_q <= cfg_wdata_i;
        REG_VWA: vwa_q <= cfg_wdata_i;
        REG_VWB: vwb_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Store writes on accepted loads
  assign det_we  = cmd_i.ld && (op_i == OP_DET) && (dcnt_q < HIT_CW'(MAX_HITS));
  assign veto_we = cmd_i.ld && (op_i == OP_VETO) && (vcnt_q < VETO_CW'(MAX_VETOES));
  assign det_addr = cmd_i.rd_j ? j_q[HIT_AW-1:0] : i_q[HIT_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (det_we) begin
      det_mem[dcnt_q[HIT_AW-1:0]] <= hit_time_i;
    end
    if (cmd_i.rd_i || cmd_i.rd_j) begin
      det_rdata_q <= det_mem[det_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (veto_we) begin
      veto_mem[vcnt_q[VETO_AW-1:0]] <= hit_time_i;
    end
    if (cmd_i.rd_v) begin
      veto_rdata_q <= veto_mem[v_q[VETO_AW-1:0]];
    end
  end

  // Shared window comparator on the signed tick difference
  assign cmp_b  = veto_sel_q ? veto_rdata_q : det_rdata_q;
  assign win_lo = veto_sel_q ? vwa_q : dpw_q;
  assign win_hi = veto_sel_q ? vwb_q : dpw_q;
  assign diff   = $signed({2'b00, ti_q}) - $signed({2'b00, cmp_b});
  assign lo_sum = diff + $signed({{(DIFF_W-WIN_W){1'b0}}, win_lo});

  // Status
  assign stat_o.i_end      = (i_q >= dcnt_q);
  assign stat_o.i_rm       = marks_q[i_q[HIT_AW-1:0]];
  assign stat_o.j_end      = (j_q >= dcnt_q);
  assign stat_o.j_rm       = marks_q[j_q[HIT_AW-1:0]];
  assign stat_o.v_end      = (v_q >= vcnt_q);
  assign stat_o.below_low  = lo_sum[DIFF_W-1];
  assign stat_o.below_high = (diff < $signed({{(DIFF_W-WIN_W){1'b0}}, win_hi}));

  // Event control state: counts, scan indexes, marks, overflow, lookahead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q      <= '0;
      vcnt_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      v_q         <= '0;
      marks_q     <= '0;
      ovf_q       <= 1'b0;
      veto_sel_q  <= 1'b0;
      have_pend_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.pend_ld && have_pend_q) || cmd_i.emit_final;
      if (det_we) begin
        dcnt_q <= dcnt_q + HIT_CW'(1);
      end
      if (veto_we) begin
        vcnt_q <= vcnt_q + VETO_CW'(1);
      end
      if (cmd_i.ld && ((op_i == OP_DET && !det_we) || (op_i == OP_VETO && !veto_we))) begin
        ovf_q <= 1'b1;
      end
      // Compare against the veto windows after a veto-store read
      if (cmd_i.rd_v) begin
        veto_sel_q <= 1'b1;
      end else if (cmd_i.rd_j) begin
        veto_sel_q <= 1'b0;
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + HIT_CW'(1);
      end
      if (cmd_i.j_set) begin
        j_q <= i_q + HIT_CW'(1);
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + HIT_CW'(1);
      end
      if (cmd_i.v_clr) begin
        v_q <= '0;
      end else if (cmd_i.v_inc) begin
        v_q <= v_q + VETO_CW'(1);
      end
      if (cmd_i.mark_j) begin
        marks_q[j_q[HIT_AW-1:0]] <= 1'b1;
      end
      if (cmd_i.mark_i) begin
        marks_q[i_q[HIT_AW-1:0]] <= 1'b1;
      end
      if (cmd_i.pend_ld) begin
        have_pend_q <= 1'b1;
      end
      if (cmd_i.clr_event) begin
        dcnt_q      <= '0;
        vcnt_q      <= '0;
        i_q         <= '0;
        marks_q     <= '0;
        ovf_q       <= 1'b0;
        have_pend_q <= 1'b0;
      end
    end
  end

  // Payload registers: current hit, lookahead and result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.ti_ld) begin
      ti_q <= det_rdata_q;
    end
    if (cmd_i.pend_ld) begin
      pend_q     <= det_rdata_q;
      res_time_q <= pend_q;
      res_kept_q <= 1'b1;
      res_last_q <= 1'b0;
      res_ovf_q  <= ovf_q;
    end
    if (cmd_i.emit_final) begin
      res_time_q <= have_pend_q ? pend_q : '0;
      res_kept_q <= have_pend_q;
      res_last_q <= 1'b1;
      res_ovf_q  <= ovf_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign kept_time_o    = res_time_q;
  assign kept_valid_o   = res_kept_q;
  assign last_o         = res_last_q;
  assign overflow_o     = res_ovf_q;

endmodule

// File: hdl/veto_coincidence_hit_filter.sv
// Top level of the anti-coincidence veto filter with double-pulse rejection.
//
// Usage: drive op_i and hit_time_i with start high while busy is low; the item
// is taken at that clock edge. Detector hits (op 0) and veto hits (op 1) are
// stored one per cycle and busy stays low, so loads may follow back to back.
// Loads beyond the buffer depth are dropped and flag overflow for the event.
// An end item (op 2) raises busy while the filter runs; op 3 is ignored.
// The filter shares one hit-store read port and one veto-store read port;
// each store read is registered before the window compare. The end item
// keeps busy high until the scans and the emit pass are done; the windows
// can end the scans early.
// Survivors come out in order on kept_time_o, one per result_valid_o pulse,
// the last one marked by last_o; an event with no survivor gives one result
// with kept_valid_o low. Each result is shown for exactly one cycle and the
// receiver cannot stall it. The user must write registers through cfg_we_i
// only while idle; the block itself does not enforce it. Reset restores the
// register defaults and empties the event; no clearing pass is needed.
module veto_coincidence_hit_filter
  import vchf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [WIN_W-1:0]  cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic [TIME_W-1:0] hit_time_i,
  output logic              result_valid_o,
  output logic [TIME_W-1:0] kept_time_o,
  output logic              kept_valid_o,
  output logic              last_o,
  output logic              overflow_o
);

  vchf_cmd_t  cmd;
  vchf_stat_t stat;

  // Sequencer
  vchf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Stores, comparator and result registers
  vchf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .hit_time_i     (hit_time_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .kept_time_o    (kept_time_o),
    .kept_valid_o   (kept_valid_o),
    .last_o         (last_o),
    .overflow_o     (overflow_o)
  );

endmodule
